>>> sv/sssc_pkg.sv
// Shared types, constants and helper functions for the seven-segment scan controller.
// Holds port words, the queued command word and the digit code table.
// No dependencies.
package sssc_pkg;

	localparam int DIGITS     = 8;
	localparam int DIGIT_IW   = $clog2(DIGITS);
	localparam int NUM_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int CONV_CW    = $clog2(NUM_W);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_RAW       = 3'd1;
	localparam logic [2:0] OP_NUM       = 3'd2;
	localparam logic [2:0] OP_NUM_DOT   = 3'd3;
	localparam logic [2:0] OP_TIME      = 3'd4;
	localparam logic [2:0] OP_BLINK_ON  = 3'd5;
	localparam logic [2:0] OP_BLINK_OFF = 3'd6;

	localparam logic [1:0] CFG_COMMON_ANODE = 2'd0;
	localparam logic [1:0] CFG_BLINK_HALF   = 2'd1;
	localparam logic [1:0] CFG_FULL_HOUR    = 2'd2;

	localparam logic [7:0] SEG_OFF        = 8'h00;
	localparam logic [7:0] SEG_DOT        = 8'h80;
	localparam logic [7:0] BLINK_HALF_RST = 8'd50;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  digit_index;
		logic [7:0]  segment_pattern;
		logic [31:0] number_value;
		logic [3:0]  dot_position;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
	} in_item_t;

	typedef struct packed {
		logic [7:0] segments;
		logic [3:0] digit_select;
	} out_item_t;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_RAW,
		CMD_NUM,
		CMD_TIME,
		CMD_BLINK_ON,
		CMD_BLINK_OFF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  dot_en;
		logic [DIGIT_IW-1:0]   idx;
		logic [7:0]            pattern;
		logic [NUM_W-1:0]      number;
		logic [6:0]            hours;
		logic [6:0]            minutes;
		logic [6:0]            seconds;
	} cmd_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] value;
	} bcd_req_t;

	typedef struct packed {
		logic                            done;
		logic [BCD_DIGITS-1:0][3:0]      digits;
	} bcd_rsp_t;

	function automatic logic [7:0] digit_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0:    c = 8'h3F;
			4'd1:    c = 8'h06;
			4'd2:    c = 8'h5B;
			4'd3:    c = 8'h4F;
			4'd4:    c = 8'h66;
			4'd5:    c = 8'h6D;
			4'd6:    c = 8'h7D;
			4'd7:    c = 8'h27;
			4'd8:    c = 8'h7F;
			4'd9:    c = 8'h6F;
			default: c = SEG_OFF;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] polar(input logic [7:0] pat, input logic anode);
		return anode ? ~pat : pat;
	endfunction

	// Tens (mod 10) and units of a 7-bit value, by shift and add-3.
	function automatic logic [7:0] bin7_to_bcd(input logic [6:0] v);
		logic [11:0] b;
		b = '0;
		for (int s = 6; s >= 0; s--) begin
			for (int n = 0; n < 3; n++) begin
				if (b[n*4 +: 4] >= 4'd5)
					b[n*4 +: 4] = b[n*4 +: 4] + 4'd3;
			end
			b = {b[10:0], v[s]};
		end
		return b[7:0];
	endfunction

endpackage

>>> sv/sssc_front.sv
// Front end: accepts input words, decodes the operation and drops words with a bad index or the unused code.
// Holds one decoded command in a register until the queue takes it.
// Depends on sssc_pkg.
module sssc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sssc_pkg::in_item_t in_data,
	output logic              push,
	output sssc_pkg::cmd_t    push_cmd,
	input  logic              q_not_full
);
	import sssc_pkg::*;

	logic keep;
	cmd_t cmd;
	logic vld_s1;
	cmd_t cmd_s1;

	always_comb begin
		cmd.kind    = CMD_TICK;
		cmd.dot_en  = 1'b0;
		cmd.idx     = in_data.digit_index[DIGIT_IW-1:0];
		cmd.pattern = in_data.segment_pattern;
		cmd.number  = in_data.number_value;
		cmd.hours   = in_data.hours;
		cmd.minutes = in_data.minutes;
		cmd.seconds = in_data.seconds;
		unique case (in_data.operation)
			OP_TICK:      cmd.kind = CMD_TICK;
			OP_RAW:       cmd.kind = CMD_RAW;
			OP_NUM:       cmd.kind = CMD_NUM;
			OP_NUM_DOT: begin
				cmd.kind   = CMD_NUM;
				cmd.dot_en = 1'b1;
				cmd.idx    = in_data.dot_position[DIGIT_IW-1:0];
			end
			OP_TIME:      cmd.kind = CMD_TIME;
			OP_BLINK_ON:  cmd.kind = CMD_BLINK_ON;
			OP_BLINK_OFF: cmd.kind = CMD_BLINK_OFF;
			default:      cmd.kind = CMD_TICK;
		endcase
	end

	// Drop bad digit indexes, bad dot positions and the unused code.
	always_comb begin
		case (in_data.operation) inside
			OP_TICK, OP_NUM, OP_TIME:
				keep = 1'b1;
			OP_RAW, OP_BLINK_ON, OP_BLINK_OFF:
				keep = in_data.digit_index < 4'(DIGITS);
			OP_NUM_DOT:
				keep = (in_data.dot_position != 4'd0) && (in_data.dot_position < 4'(DIGITS));
			default:
				keep = 1'b0;
		endcase
	end

	assign in_ready = !vld_s1 || q_not_full;
	assign push     = vld_s1 && q_not_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cmd_s1 <= '0;
		end else begin
			if (in_valid && in_ready) begin
				vld_s1 <= keep;
				cmd_s1 <= cmd;
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

>>> sv/sssc_fifo.sv
// Short command queue between the front end and the back end.
// Register based, first in first out.
// Depends on sssc_pkg.
module sssc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sssc_pkg::cmd_t push_cmd,
	output logic           not_full,
	input  logic           pop,
	output logic           q_valid,
	output sssc_pkg::cmd_t q_data
);
	import sssc_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_full = count_q != QCNT_W'(QDEPTH);
	assign q_valid  = count_q != '0;
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			for (int i = 0; i < QDEPTH; i++)
				mem_q[i] <= '0;
		end else begin
			if (push) begin
				mem_q[wr_ptr_q] <= push_cmd;
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != QCNT_W'(QDEPTH))
		else $error("push into full queue");

endmodule

>>> sv/sssc_bcd.sv
// Iterative binary to decimal converter, one shift and add-3 step per cycle.
// Produces all decimal digits of a 32-bit value.
// Depends on sssc_pkg.
module sssc_bcd (
	input  logic               clk,
	input  logic               arst_n,
	input  sssc_pkg::bcd_req_t req,
	output sssc_pkg::bcd_rsp_t rsp
);
	import sssc_pkg::*;

	logic [NUM_W-1:0]           bin_q;
	logic [BCD_DIGITS-1:0][3:0] bcd_q;
	logic [BCD_DIGITS-1:0][3:0] adj;
	logic [BCD_DIGITS*4:0]      shifted;
	logic [CONV_CW-1:0]         cnt_q;
	logic                       run_q;
	logic                       done_q;

	always_comb begin
		for (int n = 0; n < BCD_DIGITS; n++)
			adj[n] = (bcd_q[n] >= 4'd5) ? bcd_q[n] + 4'd3 : bcd_q[n];
	end

	// Shift the next binary bit in below the adjusted digits.
	assign shifted = {adj, bin_q[NUM_W-1]};

	assign rsp.done   = done_q;
	assign rsp.digits = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			bcd_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				bin_q  <= req.value;
				bcd_q  <= '0;
				cnt_q  <= '0;
				run_q  <= 1'b1;
				done_q <= 1'b0;
			end else if (run_q) begin
				bcd_q  <= shifted[BCD_DIGITS*4-1:0];
				bin_q  <= {bin_q[NUM_W-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
				done_q <= (cnt_q == CONV_CW'(NUM_W - 1));
				if (cnt_q == CONV_CW'(NUM_W - 1))
					run_q <= 1'b0;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/sssc_back.sv
// Back end: executes queued commands against the digit, blink and scan state.
// Drives the result register and the configuration registers.
// Depends on sssc_pkg and sssc_bcd.
module sssc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                q_valid,
	input  sssc_pkg::cmd_t      q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output sssc_pkg::out_item_t out_data
);
	import sssc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_CONV
	} state_t;

	state_t                     state_q;
	logic [DIGITS-1:0][7:0]     pat_q;
	logic [DIGITS-1:0]          blink_en_q;
	logic [DIGITS-1:0]          dark_q;
	logic [DIGIT_IW-1:0]        scan_q;
	logic [7:0]                 tick_q;
	logic                       dot_en_q;
	logic [DIGIT_IW-1:0]        dot_pos_q;
	logic                       out_valid_q;
	out_item_t                  out_data_q;
	logic                       anode_q;
	logic [7:0]                 half_q;
	logic                       full_hour_q;

	bcd_req_t                   bcd_req;
	bcd_rsp_t                   bcd_rsp;
	logic [8:0]                 tick_next;
	logic                       flip;
	logic [DIGITS-1:0]          dark_tick;
	logic [7:0]                 off_pat;
	logic [7:0]                 seg;
	logic [DIGITS-1:0][7:0]     int_pat;
	logic [DIGITS-1:0][7:0]     time_pat;
	logic [7:0]                 hb;
	logic [7:0]                 mb;
	logic [7:0]                 sb;

	sssc_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bcd_req),
		.rsp    (bcd_rsp)
	);

	// A tick waits for the result register to free up.
	assign pop = (state_q == ST_IDLE) && q_valid
		&& (q_data.kind != CMD_TICK || !out_valid_q || out_ready);

	assign bcd_req.start = pop && (q_data.kind == CMD_NUM);
	assign bcd_req.value = q_data.number;

	assign tick_next = {1'b0, tick_q} + 9'd1;
	assign flip      = tick_next >= {1'b0, half_q};
	assign dark_tick = flip ? (dark_q ^ blink_en_q) : dark_q;
	assign off_pat   = polar(SEG_OFF, anode_q);
	assign seg       = dark_tick[scan_q] ? off_pat : pat_q[scan_q];

	// Decimal digits to patterns; blank leading zeros but never the last digit.
	always_comb begin
		logic       lead;
		logic [3:0] d;
		lead = 1'b1;
		d    = '0;
		for (int i = 0; i < DIGITS; i++) begin
			d    = bcd_rsp.digits[DIGITS-1-i];
			lead = lead && (d == 4'd0);
			int_pat[i] = (lead && i != DIGITS - 1) ? off_pat : polar(digit_code(d), anode_q);
			if (dot_en_q && dot_pos_q == DIGIT_IW'(i))
				int_pat[i] = anode_q ? (int_pat[i] & ~SEG_DOT) : (int_pat[i] | SEG_DOT);
		end
	end

	assign hb = bin7_to_bcd(q_data.hours);
	assign mb = bin7_to_bcd(q_data.minutes);
	assign sb = bin7_to_bcd(q_data.seconds);

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			time_pat[i] = pat_q[i];
			if (i == 0)
				time_pat[i] = (!full_hour_q && hb[7:4] == 4'd0) ? off_pat
					: polar(digit_code(hb[7:4]), anode_q);
			if (i == 1) time_pat[i] = polar(digit_code(hb[3:0]), anode_q);
			if (i == 2) time_pat[i] = polar(digit_code(mb[7:4]), anode_q);
			if (i == 3) time_pat[i] = polar(digit_code(mb[3:0]), anode_q);
			if (i == 4) time_pat[i] = polar(digit_code(sb[7:4]), anode_q);
			if (i == 5) time_pat[i] = polar(digit_code(sb[3:0]), anode_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pat_q       <= '0;
			blink_en_q  <= '0;
			dark_q      <= '0;
			scan_q      <= '0;
			tick_q      <= '0;
			dot_en_q    <= 1'b0;
			dot_pos_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			anode_q     <= 1'b0;
			half_q      <= BLINK_HALF_RST;
			full_hour_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COMMON_ANODE: anode_q     <= cfg_wdata[0];
					CFG_BLINK_HALF:   half_q      <= cfg_wdata;
					CFG_FULL_HOUR:    full_hour_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			// Drop the result once taken, unless a tick refills it this cycle.
			if (out_valid_q && out_ready && !(pop && q_data.kind == CMD_TICK))
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (q_data.kind)
							CMD_TICK: begin
								tick_q      <= flip ? 8'd0 : tick_next[7:0];
								dark_q      <= dark_tick;
								out_valid_q <= 1'b1;
								out_data_q.segments     <= seg;
								out_data_q.digit_select <= 4'(scan_q);
								scan_q <= (scan_q == DIGIT_IW'(DIGITS - 1)) ? '0
									: scan_q + 1'b1;
							end
							CMD_RAW:
								pat_q[q_data.idx] <= q_data.pattern;
							CMD_NUM: begin
								dot_en_q  <= q_data.dot_en;
								dot_pos_q <= q_data.idx;
								state_q   <= ST_CONV;
							end
							CMD_TIME:
								pat_q <= time_pat;
							CMD_BLINK_ON: begin
								blink_en_q[q_data.idx] <= 1'b1;
								dark_q[q_data.idx]     <= 1'b1;
							end
							CMD_BLINK_OFF: begin
								blink_en_q[q_data.idx] <= 1'b0;
								dark_q[q_data.idx]     <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_CONV: begin
					if (bcd_rsp.done) begin
						pat_q   <= int_pat;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= DIGIT_IW'(DIGITS - 1))
		else $error("scan position out of range");
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !bcd_rsp.done)
		else $error("conversion finished while idle");
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && q_data.kind == CMD_TICK))
		else $error("result raised without a tick");

endmodule

>>> sv/seven_segment_scan_controller_core.sv
// Seven-segment scan controller, top level: front end, command queue and back end.
// A tick word's result passes the front register and the queue to the result register.
// Throughput: one tick or pattern command per cycle, except while the one-bit-per-cycle
// decimal conversion unit serves an integer command or a tick waits on the result register.
// Reset clears all patterns to off, blink state, scan position and tick count, and loads
// configuration defaults (cathode polarity, blink half period 50, leading hour zero blanked).
module seven_segment_scan_controller_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  sssc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sssc_pkg::out_item_t out_data
);
	import sssc_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_not_full;
	logic pop;
	logic q_valid;
	cmd_t q_data;

	sssc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_not_full (q_not_full)
	);

	sssc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.not_full (q_not_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	sssc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
